// File: rtl/vbg_pkg.sv
// vbg_pkg: shared constants, types and helpers for the visibility bit-plane grid.
// Used by every module of the block except vbg_ram; has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vbg_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int STORE_SIZE  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_SIZE);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int MAP_W       = 9;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 8;
    localparam int PROD_W      = 2 * MAP_W;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [MAP_W-1:0]  MAP_WIDTH_RST  = 9'd256;
    localparam logic [MAP_W-1:0]  MAP_HEIGHT_RST = 9'd256;
    localparam logic [BYTE_W-1:0] BLOCKED_RST    = 8'd0;
    localparam logic [BYTE_W-1:0] UNBLOCKED_RST  = 8'd255;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_BLOCKED    = 2'd2,
        REG_UNBLOCKED  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MAP_W-1:0]  map_width;
        logic [MAP_W-1:0]  map_height;
        logic [BYTE_W-1:0] blocked_value;
        logic [BYTE_W-1:0] unblocked_value;
    } cfg_t;

    typedef struct packed {
        logic              busy;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } sweep_t;

    // Map register limited to the grid dimension actually built.
    function automatic logic [MAP_W-1:0] active_dim(input logic [MAP_W-1:0] v,
                                                    input int unsigned lim);
        logic [MAP_W-1:0] r;
        r = v;
        if (int'(v) > int'(lim)) begin
            r = MAP_W'(lim);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/vbg_ram.sv
// vbg_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/vbg_cfg_regs.sv
// vbg_cfg_regs: APB register file for map size and alpha values.
// Depends on vbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbg_cfg_regs
    import vbg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.map_width       <= MAP_WIDTH_RST;
            cfg_reg.map_height      <= MAP_HEIGHT_RST;
            cfg_reg.blocked_value   <= BLOCKED_RST;
            cfg_reg.unblocked_value <= UNBLOCKED_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (idx)
                REG_MAP_WIDTH:  cfg_reg.map_width       <= pwdata[MAP_W-1:0];
                REG_MAP_HEIGHT: cfg_reg.map_height      <= pwdata[MAP_W-1:0];
                REG_BLOCKED:    cfg_reg.blocked_value   <= pwdata[BYTE_W-1:0];
                REG_UNBLOCKED:  cfg_reg.unblocked_value <= pwdata[BYTE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MAP_WIDTH:  prdata = APB_DATA_W'(cfg_reg.map_width);
            REG_MAP_HEIGHT: prdata = APB_DATA_W'(cfg_reg.map_height);
            REG_BLOCKED:    prdata = APB_DATA_W'(cfg_reg.blocked_value);
            REG_UNBLOCKED:  prdata = APB_DATA_W'(cfg_reg.unblocked_value);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/vbg_clear_sweep.sv
// vbg_clear_sweep: address counter that fills the first N cells, one per cycle.
// Runs a full-store zero fill out of reset. Depends on vbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbg_clear_sweep
    import vbg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  area,
    input  wire logic [BYTE_W-1:0] fill,
    output sweep_t                 sweep
);

    logic              busy_reg;
    logic [CNT_W-1:0]  addr_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [BYTE_W-1:0] fill_reg;
    logic [CNT_W-1:0]  addr_next;

    assign addr_next = addr_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b1;
            addr_reg  <= '0;
            limit_reg <= CNT_W'(STORE_SIZE);
            fill_reg  <= '0;
        end else if (busy_reg) begin
            addr_reg <= addr_next;
            if (addr_next == limit_reg) begin
                busy_reg <= 1'b0;
            end
        end else if (start) begin
            addr_reg  <= '0;
            limit_reg <= area;
            fill_reg  <= fill;
            busy_reg  <= (area != '0);
        end
    end

    assign sweep.busy = busy_reg;
    assign sweep.we   = busy_reg;
    assign sweep.addr = addr_reg[ADDR_W-1:0];
    assign sweep.data = fill_reg;

endmodule

`default_nettype wire

// File: rtl/visibility_bitplane_grid_unit.sv
// visibility_bitplane_grid_unit: byte-per-cell vision bit-plane grid in one RAM.
// Pipeline: the input transfer is registered in stage s1, then the result in the output register.
// Add, remove and read are taken back to back while the output is not stalled, set by the single RAM
// read/write port pair; a clear blocks input while it fills the active area.
// Reset: synchronous, active low; then a zero-fill of the whole RAM during which
// no input transfer is taken (configuration writes still go through).
`timescale 1ns / 1ps
`default_nettype none

module visibility_bitplane_grid_unit
    import vbg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [39:0]           s_tdata,  // column, row, source_byte, vision_mask, fill_value
    input  wire logic [1:0]            s_tuser,  // action
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [15:0]           m_tdata,  // cell_value, alpha_value
    output logic      [0:0]            m_tuser,  // out_of_range
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // ---------------------------------------------------------------- config
    cfg_t cfg;

    vbg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Map size clamped to the built grid.
    logic [MAP_W-1:0] act_w;
    logic [MAP_W-1:0] act_h;

    assign act_w = active_dim(cfg.map_width, MAX_COLUMNS);
    assign act_h = active_dim(cfg.map_height, MAX_ROWS);

    // ---------------------------------------------------------------- input unpack
    action_t            in_action;
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;
    logic [BYTE_W-1:0]  in_src;
    logic [BYTE_W-1:0]  in_mask;
    logic [BYTE_W-1:0]  in_fill;

    assign in_action = action_t'(s_tuser);
    assign in_col    = s_tdata[7:0];
    assign in_row    = s_tdata[15:8];
    assign in_src    = s_tdata[23:16];
    assign in_mask   = s_tdata[31:24];
    assign in_fill   = s_tdata[39:32];

    // Cell index row*width+col and bounds check, done at the transfer so the
    // RAM read launches the same edge.
    logic [PROD_W-1:0] idx_full;
    logic [ADDR_W-1:0] in_idx;
    logic              in_oor;

    assign idx_full = PROD_W'(in_row) * PROD_W'(act_w) + PROD_W'(in_col);
    assign in_idx   = (idx_full > PROD_W'(STORE_SIZE - 1)) ? ADDR_W'(STORE_SIZE - 1)
                                                           : idx_full[ADDR_W-1:0];
    assign in_oor   = (MAP_W'(in_col) >= act_w) || (MAP_W'(in_row) >= act_h);

    // ---------------------------------------------------------------- pipeline regs
    logic              s1_valid_reg;
    action_t           s1_action_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic              s1_oor_reg;
    logic [BYTE_W-1:0] s1_src_reg;
    logic [BYTE_W-1:0] s1_mask_reg;
    logic [BYTE_W-1:0] s1_fill_reg;

    logic              m_valid_reg;
    logic [15:0]       m_tdata_reg;
    logic [0:0]        m_tuser_reg;

    // Most recent RAM write, for the read that launched on the same edge.
    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_idx_reg;
    logic [BYTE_W-1:0] lw_data_reg;

    sweep_t            sweep;
    logic              in_xfer;
    logic              s1_adv;
    logic              clear_start;
    logic [CNT_W-1:0]  clear_area;
    logic [PROD_W-1:0] area_full;

    assign s1_adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign clear_start = s1_adv && (s1_action_reg == ACT_CLEAR);

    // Hold off while filling, and on the edge a clear hands over to the sweep.
    assign s_tready = !sweep.busy &&
                      (!s1_valid_reg || (s1_adv && (s1_action_reg != ACT_CLEAR)));
    assign in_xfer  = s_tvalid && s_tready;

    assign area_full  = PROD_W'(act_w) * PROD_W'(act_h);
    assign clear_area = (area_full > PROD_W'(STORE_SIZE)) ? CNT_W'(STORE_SIZE)
                                                          : area_full[CNT_W-1:0];

    // ---------------------------------------------------------------- cell RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    logic              item_we;

    vbg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_SIZE)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    vbg_clear_sweep u_sweep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (clear_start),
        .area    (clear_area),
        .fill    (s1_fill_reg),
        .sweep   (sweep)
    );

    // ---------------------------------------------------------------- modify
    logic [BYTE_W-1:0] base_cell;
    logic [BYTE_W-1:0] bits;
    logic [BYTE_W-1:0] new_cell;
    logic [BYTE_W-1:0] res_cell;
    logic [BYTE_W-1:0] res_alpha;

    assign base_cell = (lw_valid_reg && (lw_idx_reg == s1_idx_reg)) ? lw_data_reg
                                                                    : ram_rdata;
    assign bits = s1_src_reg & s1_mask_reg;

    always_comb begin
        case (s1_action_reg)
            ACT_ADD:    new_cell = base_cell | bits;
            // zero source leaves the cell alone
            ACT_REMOVE: new_cell = (s1_src_reg != '0) ? (base_cell & ~bits) : base_cell;
            ACT_CLEAR:  new_cell = s1_fill_reg;
            default:    new_cell = base_cell;
        endcase
    end

    // Outside the map: empty cell reported, flag set; clear never flags.
    assign res_cell  = (s1_oor_reg && (s1_action_reg != ACT_CLEAR)) ? '0 : new_cell;
    assign res_alpha = (res_cell != '0) ? cfg.blocked_value : cfg.unblocked_value;

    assign item_we = s1_adv && !s1_oor_reg &&
                     ((s1_action_reg == ACT_ADD) || (s1_action_reg == ACT_REMOVE));

    assign ram_we    = sweep.we || item_we;
    assign ram_waddr = sweep.we ? sweep.addr : s1_idx_reg;
    assign ram_wdata = sweep.we ? sweep.data : new_cell;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_action_reg <= in_action;
            s1_idx_reg    <= in_idx;
            s1_oor_reg    <= in_oor;
            s1_src_reg    <= in_src;
            s1_mask_reg   <= in_mask;
            s1_fill_reg   <= in_fill;
        end
        if (s1_adv) begin
            m_tdata_reg <= {res_alpha, res_cell};
            m_tuser_reg <= (s1_action_reg != ACT_CLEAR) ? s1_oor_reg : 1'b0;
        end
        if (ram_we) begin
            lw_idx_reg  <= ram_waddr;
            lw_data_reg <= ram_wdata;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------- assertions
    // No item may enter while the fill owns the write port.
    a_no_xfer_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |-> !sweep.busy)
        else $error("input transfer during clear sweep");

    // Item writes and sweep writes never collide.
    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        item_we |-> !sweep.busy)
        else $error("item write during clear sweep");

    // A clear over a nonempty area starts the sweep on the next cycle.
    a_clear_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (clear_start && (clear_area != '0)) |=> sweep.busy)
        else $error("clear did not start sweep");

    // A flagged result reports an empty cell.
    a_oor_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
        else $error("out-of-range result with nonzero cell");

endmodule

`default_nettype wire
